// ===== rtl/track_polyline_rasterizer_defines.svh =====
// Assertion macros for the track polyline rasterizer.
// The including scope must provide clk_i and rst_ni.
`ifndef TRACK_POLYLINE_RASTERIZER_DEFINES_SVH
`define TRACK_POLYLINE_RASTERIZER_DEFINES_SVH

// Check a property while out of reset.
`define TPR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/tpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types, codes and helpers of the track polyline rasterizer.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int LON_W      = 32;
  localparam int LAT_W      = 31;
  localparam int SCALE_W    = 32;
  localparam int LIMIT_W    = 9;
  localparam int IDX_W      = 7;
  localparam int WORD_W     = 64;
  localparam int COORD_W    = 11;
  localparam int ERR_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 9'd300;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LAT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_POINT = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROJ_X,
    ST_PROJ_Y,
    ST_SAT_Y,
    ST_PREP,
    ST_DRAW,
    ST_FLUSH,
    ST_READ,
    ST_CLEAR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic proj_x;
    logic proj_y;
    logic sat_y;
    logic prep;
    logic draw;
    logic clear;
    logic read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic  in_fire;
    func_e func;
    logic  draw_go;
    logic  last;
    logic  clr_done;
    logic  out_free;
  } status_t;

  // Saturate a projected value to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [34:0] v);
    logic signed [COORD_W-1:0] r;
    if (v < -35'sd1024) begin
      r = -11'sd1024;
    end else if (v > 35'sd1023) begin
      r = 11'sd1023;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tpr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_if
// Valid/ready channels of the rasterizer: input items, results, config.
// ----------------------------------------------------------------------------
interface tpr_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [tpr_pkg::LON_W-1:0]    point_lon;
  logic signed [tpr_pkg::LAT_W-1:0]    point_lat;
  logic                                starts_track;
  logic [tpr_pkg::IDX_W-1:0]           word_index;
  modport source (output valid, func, point_lon, point_lat, starts_track, word_index,
                  input ready);
  modport sink   (input valid, func, point_lon, point_lat, starts_track, word_index,
                  output ready);
endinterface

interface tpr_out_if;
  logic                          valid;
  logic                          ready;
  logic [tpr_pkg::WORD_W-1:0]    read_data;
  logic [tpr_pkg::LIMIT_W-1:0]   pixels_set;
  logic                          segment_skipped;
  modport source (output valid, read_data, pixels_set, segment_skipped, input ready);
  modport sink   (input valid, read_data, pixels_set, segment_skipped, output ready);
endinterface

interface tpr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tpr_pkg::CFG_IDX_W-1:0]     index;
  logic [tpr_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_ctrl
// Sequencer: steps the datapath through projection, drawing, clear and read.
// ----------------------------------------------------------------------------
module tpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpr_pkg::status_t status_i,
  output tpr_pkg::cmd_t    cmd_o
);

  tpr_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpr_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      tpr_pkg::ST_INIT: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_done) state_d = tpr_pkg::ST_IDLE;
      end
      tpr_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_fire) begin
          unique case (status_i.func)
            tpr_pkg::FUNC_CLEAR: state_d = tpr_pkg::ST_CLEAR;
            tpr_pkg::FUNC_POINT: state_d = tpr_pkg::ST_PROJ_X;
            tpr_pkg::FUNC_READ:  state_d = tpr_pkg::ST_READ;
            default:             state_d = tpr_pkg::ST_OUT;
          endcase
        end
      end
      tpr_pkg::ST_PROJ_X: begin
        cmd_o.proj_x = 1'b1;
        state_d = tpr_pkg::ST_PROJ_Y;
      end
      tpr_pkg::ST_PROJ_Y: begin
        cmd_o.proj_y = 1'b1;
        state_d = tpr_pkg::ST_SAT_Y;
      end
      tpr_pkg::ST_SAT_Y: begin
        cmd_o.sat_y = 1'b1;
        state_d = tpr_pkg::ST_PREP;
      end
      tpr_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = status_i.draw_go ? tpr_pkg::ST_DRAW : tpr_pkg::ST_OUT;
      end
      tpr_pkg::ST_DRAW: begin
        cmd_o.draw = 1'b1;
        if (status_i.last) state_d = tpr_pkg::ST_FLUSH;
      end
      tpr_pkg::ST_FLUSH: begin
        state_d = tpr_pkg::ST_OUT;
      end
      tpr_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = tpr_pkg::ST_OUT;
      end
      tpr_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_done) state_d = tpr_pkg::ST_OUT;
      end
      tpr_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = tpr_pkg::ST_IDLE;
        end
      end
      default: state_d = tpr_pkg::ST_INIT;
    endcase
  end

endmodule

// ===== rtl/tpr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_datapath
// Config registers, projection multiplier, Bresenham stepper, frame store
// with read-modify-write pipeline, and the result register.
// ----------------------------------------------------------------------------
module tpr_datapath #(
  parameter int CANVAS_WIDTH  = 128,
  parameter int CANVAS_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tpr_in_if.sink            in_i,
  tpr_out_if.source         out_o,
  tpr_cfg_if.sink           cfg_i,
  input  tpr_pkg::cmd_t     cmd_i,
  output tpr_pkg::status_t  status_o
);

  localparam int WPR   = (CANVAS_WIDTH + 63) / 64;
  localparam int DEPTH = CANVAS_HEIGHT * WPR;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = tpr_pkg::COORD_W;
  localparam int EW    = tpr_pkg::ERR_W;

  localparam logic signed [34:0] Y_TOP = 35'(CANVAS_HEIGHT - 1);
  localparam logic signed [11:0] X_LO  = 12'(-CANVAS_WIDTH);
  localparam logic signed [11:0] X_HI  = 12'(2 * CANVAS_WIDTH);
  localparam logic signed [11:0] Y_LO  = 12'(-CANVAS_HEIGHT);
  localparam logic signed [11:0] Y_HI  = 12'(2 * CANVAS_HEIGHT);
  localparam logic signed [CW-1:0] X_END = CW'(CANVAS_WIDTH);
  localparam logic signed [CW-1:0] Y_END = CW'(CANVAS_HEIGHT);

  // -------- configuration registers --------
  logic signed [tpr_pkg::LON_W-1:0] min_lon_q;
  logic signed [tpr_pkg::LAT_W-1:0] min_lat_q;
  logic [tpr_pkg::SCALE_W-1:0]      x_scale_q, y_scale_q;
  logic [tpr_pkg::LIMIT_W-1:0]      step_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lon_q    <= '0;
      min_lat_q    <= '0;
      x_scale_q    <= '0;
      y_scale_q    <= '0;
      step_limit_q <= tpr_pkg::STEP_LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tpr_pkg::REG_MIN_LON:    min_lon_q    <= cfg_i.data;
        tpr_pkg::REG_MIN_LAT:    min_lat_q    <= cfg_i.data[tpr_pkg::LAT_W-1:0];
        tpr_pkg::REG_X_SCALE:    x_scale_q    <= cfg_i.data;
        tpr_pkg::REG_Y_SCALE:    y_scale_q    <= cfg_i.data;
        tpr_pkg::REG_STEP_LIMIT: step_limit_q <= cfg_i.data[tpr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // -------- input beat capture --------
  logic                              in_fire;
  tpr_pkg::func_e                    func_q;
  logic signed [tpr_pkg::LON_W-1:0]  lon_q;
  logic signed [tpr_pkg::LAT_W-1:0]  lat_q;
  logic                              starts_q;
  logic [tpr_pkg::IDX_W-1:0]         widx_q;

  assign in_i.ready = cmd_i.in_ready;
  assign in_fire    = in_i.valid & cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= tpr_pkg::func_e'(in_i.func);
      lon_q    <= in_i.point_lon;
      lat_q    <= in_i.point_lat;
      starts_q <= in_i.starts_track;
      widx_q   <= in_i.word_index;
    end
  end

  // -------- projection: one shared 32x32 multiplier --------
  logic signed [32:0] dlon, dlon_neg;
  logic signed [31:0] dlat, dlat_neg;
  logic [31:0]        lon_mag, lat_mag, mul_a, mul_b;
  logic [63:0]        prod_q;
  logic               neg_q;
  logic [33:0]        proj_s;
  logic signed [34:0] proj_ext, y_val;
  logic signed [CW-1:0] x1_q, y1_q;

  assign dlon     = {lon_q[31], lon_q} - {min_lon_q[31], min_lon_q};
  assign dlon_neg = -dlon;
  assign lon_mag  = dlon[32] ? dlon_neg[31:0] : dlon[31:0];
  assign dlat     = {lat_q[30], lat_q} - {min_lat_q[30], min_lat_q};
  assign dlat_neg = -dlat;
  assign lat_mag  = dlat[31] ? {1'b0, dlat_neg[30:0]} : {1'b0, dlat[30:0]};
  assign mul_a    = cmd_i.proj_x ? lon_mag : lat_mag;
  assign mul_b    = cmd_i.proj_x ? x_scale_q : y_scale_q;

  // Apply the sign after the shift: truncation toward zero
  assign proj_s   = neg_q ? -{2'b00, prod_q[63:32]} : {2'b00, prod_q[63:32]};
  assign proj_ext = {proj_s[33], proj_s};
  assign y_val    = Y_TOP - proj_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.proj_x || cmd_i.proj_y) begin
      prod_q <= mul_a * mul_b;
      neg_q  <= cmd_i.proj_x ? dlon[32] : dlat[31];
    end
    if (cmd_i.proj_y) x1_q <= tpr_pkg::sat_coord(proj_ext);
    if (cmd_i.sat_y)  y1_q <= tpr_pkg::sat_coord(y_val);
  end

  // -------- segment setup --------
  logic signed [CW-1:0] prev_x_q, prev_y_q;
  logic                 prev_valid_q;
  logic signed [11:0]   x0e, x1e, y0e, y1e, dxs, dys, dx_abs, dy_abs;
  logic                 far, draws;

  assign x0e    = {prev_x_q[CW-1], prev_x_q};
  assign y0e    = {prev_y_q[CW-1], prev_y_q};
  assign x1e    = {x1_q[CW-1], x1_q};
  assign y1e    = {y1_q[CW-1], y1_q};
  assign dxs    = x1e - x0e;
  assign dys    = y1e - y0e;
  assign dx_abs = dxs[11] ? -dxs : dxs;
  assign dy_abs = dys[11] ? -dys : dys;
  assign far    = (x0e < X_LO && x1e < X_LO) || (x0e > X_HI && x1e > X_HI) ||
                  (y0e < Y_LO && y1e < Y_LO) || (y0e > Y_HI && y1e > Y_HI);
  assign draws  = !starts_q && prev_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_valid_q <= 1'b0;
    end else if (cmd_i.prep) begin
      prev_x_q     <= x1_q;
      prev_y_q     <= y1_q;
      prev_valid_q <= 1'b1;
    end
  end

  // -------- Bresenham stepper: one position per cycle --------
  logic signed [CW-1:0]   cx_q, cy_q, ex_q, ey_q;
  logic signed [11:0]     dx_q, dy_q;
  logic                   sx_q, sy_q;
  logic signed [EW-1:0]   err_q, err_d;
  logic signed [EW:0]     e2;
  logic [tpr_pkg::LIMIT_W-1:0] step_cnt_q, pix_cnt_q;
  logic                   skip_q;
  logic                   visible, at_end, step_x, step_y;
  logic [AW-1:0]          draw_addr;

  assign visible = !cx_q[CW-1] && (cx_q < X_END) && !cy_q[CW-1] && (cy_q < Y_END);
  assign at_end  = (cx_q == ex_q) && (cy_q == ey_q);
  assign e2      = {err_q, 1'b0};
  assign step_x  = e2 >= (EW+1)'(dy_q);
  assign step_y  = e2 <= (EW+1)'(dx_q);

  always_comb begin
    err_d = err_q;
    if (step_x) err_d = err_d + EW'(dy_q);
    if (step_y) err_d = err_d + EW'(dx_q);
  end

  assign draw_addr = AW'({24'd0, cy_q[7:0]} * 32'(WPR) + {30'd0, cx_q[7:6]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      cx_q       <= prev_x_q;
      cy_q       <= prev_y_q;
      ex_q       <= x1_q;
      ey_q       <= y1_q;
      dx_q       <= dx_abs;
      dy_q       <= -dy_abs;
      sx_q       <= x0e < x1e;
      sy_q       <= y0e < y1e;
      err_q      <= EW'(dx_abs) - EW'(dy_abs);
      step_cnt_q <= '0;
    end else if (cmd_i.draw) begin
      step_cnt_q <= step_cnt_q + 1'b1;
      err_q      <= err_d;
      if (step_x) cx_q <= sx_q ? cx_q + 1'b1 : cx_q - 1'b1;
      if (step_y) cy_q <= sy_q ? cy_q + 1'b1 : cy_q - 1'b1;
    end
  end

  // Result fields of the current item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_cnt_q <= '0;
      skip_q    <= 1'b0;
    end else begin
      if (cmd_i.prep) skip_q <= draws && far;
      if (cmd_i.draw && visible) pix_cnt_q <= pix_cnt_q + 1'b1;
    end
  end

  // -------- frame store and read-modify-write pipeline --------
  logic [tpr_pkg::WORD_W-1:0] mem [DEPTH];
  logic [tpr_pkg::WORD_W-1:0] rdata_q, w_data_q, merged, mem_wdata;
  logic [AW-1:0]  p_addr_q, w_addr_q, clr_cnt_q, mem_waddr, mem_raddr;
  logic [5:0]     p_bit_q;
  logic           p_valid_q, w_valid_q, mem_we, mem_re, clr_done, in_range;

  assign clr_done  = clr_cnt_q == AW'(DEPTH - 1);
  assign in_range  = 32'(widx_q) < DEPTH;
  // Forward the word written last cycle: the store read missed it
  assign merged    = (w_valid_q && w_addr_q == p_addr_q) ? w_data_q : rdata_q;
  assign mem_we    = cmd_i.clear || p_valid_q;
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : p_addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : (merged | (64'd1 << p_bit_q));
  assign mem_re    = cmd_i.read || (cmd_i.draw && visible);
  assign mem_raddr = cmd_i.read ? AW'(widx_q) : draw_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    p_addr_q <= draw_addr;
    p_bit_q  <= cx_q[5:0];
    w_addr_q <= p_addr_q;
    w_data_q <= mem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      p_valid_q <= cmd_i.draw && visible;
      w_valid_q <= p_valid_q;
      if (cmd_i.clear) clr_cnt_q <= clr_done ? '0 : clr_cnt_q + 1'b1;
    end
  end

  // -------- result register --------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.read_data       <= (func_q == tpr_pkg::FUNC_READ && in_range) ? rdata_q : '0;
      out_o.pixels_set      <= (func_q == tpr_pkg::FUNC_POINT) ? pix_cnt_q : '0;
      out_o.segment_skipped <= (func_q == tpr_pkg::FUNC_POINT) && skip_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // -------- status --------
  assign status_o.in_fire  = in_fire;
  assign status_o.func     = tpr_pkg::func_e'(in_i.func);
  assign status_o.draw_go  = draws && !far && (step_limit_q != '0);
  assign status_o.last     = at_end || ({1'b0, step_cnt_q} + 10'd1 == {1'b0, step_limit_q});
  assign status_o.clr_done = clr_done;
  assign status_o.out_free = !out_valid_q || out_o.ready;

endmodule

// ===== rtl/track_polyline_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_polyline_rasterizer
// Projects track points to a 1-bit canvas and joins them with Bresenham lines.
//
//  channel  dir  beat content
//  in_i     in   func, point_lon, point_lat, starts_track, word_index
//  out_o    out  read_data, pixels_set, segment_skipped (one per input beat)
//  cfg_i    in   index, data (register write, always ready)
//
// A track point passes PROJ_X, PROJ_Y, SAT_Y and PREP, then, when a segment is
// drawn, DRAW for each pixel position visited (up to step_limit) and FLUSH,
// and last OUT. A read passes READ and OUT. A clear writes one store word per
// cycle in CLEAR, then passes OUT. The single write port of the store and the
// stepper set the pace. After reset the store is swept to zero in the same way
// with in_i.ready low. OUT waits until the result register is free; a held
// result does not block accepting the next beat.
// ----------------------------------------------------------------------------
module track_polyline_rasterizer #(
  parameter int CANVAS_WIDTH  = 128,
  parameter int CANVAS_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpr_in_if.sink     in_i,
  tpr_out_if.source  out_o,
  tpr_cfg_if.sink    cfg_i
);

  tpr_pkg::cmd_t    cmd;
  tpr_pkg::status_t status;

  tpr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tpr_datapath #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

// ===== rtl/tpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_checker
// Port-level checks of the rasterizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "track_polyline_rasterizer_defines.svh"

module tpr_prop_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tpr_pkg::LIMIT_W-1:0]   pixels_set_i,
  input logic                          skipped_i
);

  // Hold a result beat until taken
  `TPR_ASSERT_RST(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  // Drop input ready after an accepted beat
  `TPR_ASSERT_RST(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i, "second beat taken")
  // A skipped segment sets no pixel
  `TPR_ASSERT_RST(a_skip_zero, out_valid_i && skipped_i |-> pixels_set_i == 0, "skip with pixels")
  // No result while in reset
  `TPR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_i, "result during reset")

endmodule

bind track_polyline_rasterizer tpr_prop_checker u_tpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .pixels_set_i (out_o.pixels_set),
  .skipped_i    (out_o.segment_skipped)
);

// ===== dv/tpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_checker
// Passive checker of the track polyline rasterizer. Watches the config, input
// and result channels, keeps its own copy of the canvas and the registers,
// predicts one result per input beat and compares result beats in order.
// ----------------------------------------------------------------------------
module tpr_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tpr_in_if    in_mon,
  tpr_out_if   out_mon,
  tpr_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   segments_o,
  output int   skips_o
);

  localparam int CW    = 128;
  localparam int CH    = 64;
  localparam int WPR   = (CW + 63) / 64;
  localparam int DEPTH = CH * WPR;

  typedef struct packed {
    logic [tpr_pkg::WORD_W-1:0]  read_data;
    logic [tpr_pkg::LIMIT_W-1:0] pixels_set;
    logic                        segment_skipped;
  } result_t;

  logic [tpr_pkg::WORD_W-1:0] canvas_q [DEPTH];
  result_t           result_q [$];
  longint            min_lon_q, min_lat_q;
  logic [31:0]       x_scale_q, y_scale_q;
  int                step_limit_q;
  int                last_x_q, last_y_q;
  bit                last_valid_q;

  // Scale an offset and truncate toward zero
  function automatic longint scale_offset(longint d, logic [31:0] sc);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (d < 0) ? -d : d;
    p   = (mag * {32'b0, sc}) >> 32;
    return (d < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic int clamp_coord(longint v);
    if (v < -1024) return -1024;
    if (v > 1023) return 1023;
    return int'(v);
  endfunction

  // Walk a Bresenham line, set on-canvas bits, return the write count
  function automatic int plot_line(int x0, int y0, int x1, int y1);
    int dx, dy, sx, sy, err, e2, steps, cnt;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    steps = 0;
    cnt = 0;
    while (steps < step_limit_q) begin
      steps++;
      if (x0 >= 0 && x0 < CW && y0 >= 0 && y0 < CH) begin
        canvas_q[y0 * WPR + (x0 >> 6)][x0 & 63] = 1'b1;
        cnt++;
      end
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0 += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0 += sy;
      end
    end
    return cnt;
  endfunction

  // Compute the result of one input beat and advance the model state
  function automatic result_t predict_beat(tpr_pkg::func_e fn, longint lon, longint lat,
                                           bit st, int wi);
    result_t r;
    int      x1, y1, pix;
    bit      far;
    r = '0;
    case (fn)
      tpr_pkg::FUNC_CLEAR: begin
        foreach (canvas_q[i]) canvas_q[i] = '0;
      end
      tpr_pkg::FUNC_READ: begin
        if (wi < DEPTH) r.read_data = canvas_q[wi];
      end
      tpr_pkg::FUNC_POINT: begin
        x1 = clamp_coord(scale_offset(lon - min_lon_q, x_scale_q));
        y1 = clamp_coord(longint'(CH - 1) - scale_offset(lat - min_lat_q, y_scale_q));
        if (!st && last_valid_q) begin
          far = (last_x_q < -CW && x1 < -CW) || (last_x_q > 2 * CW && x1 > 2 * CW) ||
                (last_y_q < -CH && y1 < -CH) || (last_y_q > 2 * CH && y1 > 2 * CH);
          if (far) begin
            r.segment_skipped = 1'b1;
            skips_o++;
          end else begin
            pix = plot_line(last_x_q, last_y_q, x1, y1);
            r.pixels_set = pix[tpr_pkg::LIMIT_W-1:0];
            segments_o++;
          end
        end
        last_x_q = x1;
        last_y_q = y1;
        last_valid_q = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track registers, predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      foreach (canvas_q[i]) canvas_q[i] = '0;
      result_q.delete();
      min_lon_q = 0;
      min_lat_q = 0;
      x_scale_q = '0;
      y_scale_q = '0;
      step_limit_q = int'(tpr_pkg::STEP_LIMIT_RST);
      last_x_q = 0;
      last_y_q = 0;
      last_valid_q = 1'b0;
      fail_count_o = 0;
      segments_o = 0;
      skips_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          tpr_pkg::REG_MIN_LON:    min_lon_q = longint'($signed(cfg_mon.data));
          tpr_pkg::REG_MIN_LAT:
            min_lat_q = longint'($signed(cfg_mon.data[tpr_pkg::LAT_W-1:0]));
          tpr_pkg::REG_X_SCALE:    x_scale_q = cfg_mon.data;
          tpr_pkg::REG_Y_SCALE:    y_scale_q = cfg_mon.data;
          tpr_pkg::REG_STEP_LIMIT:
            step_limit_q = int'(cfg_mon.data[tpr_pkg::LIMIT_W-1:0]);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("[%0t] result beat with nothing pending", $realtime);
        end else begin
          exp_r = result_q.pop_front();
          if (out_mon.read_data !== exp_r.read_data ||
              out_mon.pixels_set !== exp_r.pixels_set ||
              out_mon.segment_skipped !== exp_r.segment_skipped) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("[%0t] mismatch: read_data exp %h got %h, pixels_set exp %0d got %0d,",
                       $realtime, exp_r.read_data, out_mon.read_data, exp_r.pixels_set,
                       out_mon.pixels_set);
              $display("  segment_skipped exp %0b got %0b", exp_r.segment_skipped,
                       out_mon.segment_skipped);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        result_q.push_back(predict_beat(tpr_pkg::func_e'(in_mon.func),
                                        longint'(in_mon.point_lon),
                                        longint'(in_mon.point_lat), in_mon.starts_track,
                                        int'(in_mon.word_index)));
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== dv/tb_track_polyline_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_polyline_rasterizer
// Drives config writes, track points, clears and reads into the rasterizer
// with random gaps and result back-pressure; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_track_polyline_rasterizer;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 62;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending, segments, skips;
  int   in_gap_max, out_gap_max;
  int   items_sent, idle_cycles;
  longint view_lon, view_lat, view_span;

  tpr_in_if  in_ch ();
  tpr_out_if out_ch ();
  tpr_cfg_if cfg_ch ();

  track_polyline_rasterizer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  tpr_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .segments_o  (segments),
    .skips_o     (skips)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Abort when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the result side for a random gap before each beat
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = $urandom_range(out_gap_max, 0);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (out_ch.valid) break;
      end
    end
  end

  // Write one register, then drop valid so the next write is not back to back
  task automatic write_reg(logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                           logic [tpr_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (cfg_ch.ready) break;
    end
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Send one input beat after a random gap; returns at a falling edge
  task automatic send_item(tpr_pkg::func_e fn, longint lon, longint lat, bit st, int wi);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.func         <= fn;
    in_ch.point_lon    <= lon[tpr_pkg::LON_W-1:0];
    in_ch.point_lat    <= lat[tpr_pkg::LAT_W-1:0];
    in_ch.starts_track <= st;
    in_ch.word_index   <= wi[tpr_pkg::IDX_W-1:0];
    in_ch.valid        <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    @(negedge clk_i);
    items_sent++;
  endtask

  // Drain all results before touching registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Program a view of span units wide and high anchored at (lon0, lat0), and the step limit
  task automatic set_view(longint lon0, longint lat0, longint span, int limit);
    logic [63:0] xs, ys;
    view_lon  = lon0;
    view_lat  = lat0;
    view_span = span;
    xs = (64'd127 << 32) / span;
    ys = (64'd63 << 32) / span;
    write_reg(tpr_pkg::REG_MIN_LON, lon0[31:0]);
    write_reg(tpr_pkg::REG_MIN_LAT, lat0[31:0]);
    write_reg(tpr_pkg::REG_X_SCALE, xs[31:0]);
    write_reg(tpr_pkg::REG_Y_SCALE, ys[31:0]);
    write_reg(tpr_pkg::REG_STEP_LIMIT, limit[31:0]);
  endtask

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Send a point near or inside the current view
  task automatic send_near(bit st);
    longint lon, lat, q;
    q = view_span / 4;
    lon = view_lon - q + longint'($urandom_range(32'(view_span + 2 * q), 0));
    lat = view_lat - q + longint'($urandom_range(32'(view_span + 2 * q), 0));
    send_item(tpr_pkg::FUNC_POINT, clip(lon, 1800000000), clip(lat, 900000000), st, 0);
  endtask

  task automatic send_wild();
    longint lon, lat;
    lon = longint'($urandom_range(32'd3600000000, 0)) - 1800000000;
    lat = longint'($urandom_range(32'd1800000000, 0)) - 900000000;
    send_item(tpr_pkg::FUNC_POINT, lon, lat, $urandom_range(1, 0), 0);
  endtask

  initial begin
    int roll, limit;
    longint span;
    rst_ni = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = tpr_pkg::FUNC_CLEAR;
    in_ch.point_lon = '0;
    in_ch.point_lat = '0;
    in_ch.starts_track = 1'b0;
    in_ch.word_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tpr_pkg::REG_MIN_LON;
    cfg_ch.data = '0;
    items_sent = 0;
    in_gap_max = 3;
    out_gap_max = 3;
    #1;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset state, unused func, first point without a previous one
    send_item(tpr_pkg::FUNC_READ, 0, 0, 0, 0);
    send_item(tpr_pkg::FUNC_NONE, 123, -456, 1, 5);
    send_item(tpr_pkg::FUNC_POINT, 1800000000, 900000000, 0, 0);
    send_item(tpr_pkg::FUNC_POINT, -1800000000, -900000000, 0, 0);
    wait_idle();
    set_view(0, 0, 10000, 300);
    send_item(tpr_pkg::FUNC_POINT, 0, 0, 1, 0);
    send_item(tpr_pkg::FUNC_POINT, 10000, 10000, 0, 0);
    send_item(tpr_pkg::FUNC_POINT, 10000, 10000, 0, 0);
    send_item(tpr_pkg::FUNC_POINT, 0, 10000, 0, 0);
    send_item(tpr_pkg::FUNC_READ, 0, 0, 0, 0);
    send_item(tpr_pkg::FUNC_READ, 0, 0, 0, 1);
    send_item(tpr_pkg::FUNC_READ, 0, 0, 0, 127);
    // Far left on both ends is rejected, far coordinates saturate
    send_item(tpr_pkg::FUNC_POINT, -1800000000, 5000, 1, 0);
    send_item(tpr_pkg::FUNC_POINT, -1700000000, 2000, 0, 0);
    send_item(tpr_pkg::FUNC_POINT, 1800000000, -900000000, 0, 0);
    send_item(tpr_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    send_item(tpr_pkg::FUNC_READ, 0, 0, 0, 64);
    wait_idle();
    write_reg(tpr_pkg::REG_STEP_LIMIT, 32'd1);
    send_item(tpr_pkg::FUNC_POINT, 5000, 5000, 0, 0);
    wait_idle();
    write_reg(tpr_pkg::REG_STEP_LIMIT, 32'd0);
    send_item(tpr_pkg::FUNC_POINT, 0, 0, 0, 0);
    send_item(tpr_pkg::FUNC_POINT, 9000, 1000, 0, 0);
    wait_idle();
    write_reg(tpr_pkg::REG_STEP_LIMIT, 32'd511);
    write_reg(tpr_pkg::REG_X_SCALE, 32'hFFFF_FFFF);
    write_reg(tpr_pkg::REG_Y_SCALE, 32'hFFFF_FFFF);
    send_item(tpr_pkg::FUNC_POINT, 3, 3, 1, 0);
    send_item(tpr_pkg::FUNC_POINT, -2000, 900000000, 0, 0);
    send_item(tpr_pkg::FUNC_READ, 0, 0, 0, 2);
    wait_idle();

    // Random phases with a fresh view and step limit each time
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: span = 5000 + $urandom_range(5000, 0);
        1: span = 100000 + $urandom_range(10000000, 0);
        2: span = 60 + $urandom_range(200, 0);
        default: span = 1000000 + $urandom_range(100000000, 0);
      endcase
      case (ph)
        0: limit = 300;
        1: limit = 511;
        2: limit = 1;
        3: limit = 0;
        default: limit = $urandom_range(511, 1);
      endcase
      in_gap_max  = (ph == 2) ? 0 : 10;
      out_gap_max = (ph == 2 || ph == 5) ? 0 : 10;
      set_view(longint'($urandom_range(32'd3000000000, 0)) - 1500000000,
               longint'($urandom_range(32'd1500000000, 0)) - 750000000, span, limit);
      send_item(tpr_pkg::FUNC_CLEAR, 0, 0, 0, 0);
      send_near(1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99, 0);
        if (roll < 70) send_near($urandom_range(9, 0) == 0);
        else if (roll < 78) send_wild();
        else if (roll < 92) send_item(tpr_pkg::FUNC_READ, 0, 0, 0, $urandom_range(127, 0));
        else if (roll < 95) send_item(tpr_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        else send_item(tpr_pkg::FUNC_NONE, $urandom(), $urandom(), $urandom_range(1, 0),
                       $urandom_range(127, 0));
      end
      // Sweep the canvas at random strides of one to four words to check the drawn pattern
      for (int w = 0; w < 128; w += 1 + $urandom_range(3, 0)) begin
        send_item(tpr_pkg::FUNC_READ, 0, 0, 0, w);
      end
      wait_idle();
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("sent %0d items over %0d random views and a directed set,", items_sent,
             RANDOM_PHASES);
    $display("%0d segments drawn, %0d rejected off-screen", segments, skips);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
